// ===== hdl/laplacian_edge_filter_3x3_top_assert.svh =====
// Assertion macros used by the checker file of the edge filter.
`ifndef LAPLACIAN_EDGE_FILTER_3X3_TOP_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_3X3_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define LEF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LEF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lef_pkg.sv =====
// Shared constants, register indexes and types of the 3x3 Laplacian edge filter.
package lef_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MIN_DIM        = 3;

   localparam int PIX_W          = 8;
   localparam int COL_OUT_W      = 11;
   localparam int ROW_W          = 16;
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_ADDR_W     = 2;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_WEIGHT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT  = 2'd2;

   localparam logic signed [PIX_W-1:0]        CENTER_WEIGHT_RST = 8'sd8;
   localparam logic [FRAME_WIDTH_W-1:0]       FRAME_WIDTH_RST   = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0]      FRAME_HEIGHT_RST  = 16'd480;

   // result queue depth, power of two
   localparam int RSP_DEPTH = 4;

   // 3x3 red window; index 4 is the center, 2/5/8 the newest column
   typedef logic [8:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic [PIX_W-1:0]     red;
      logic [PIX_W-1:0]     green;
      logic [PIX_W-1:0]     blue;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type first;
      logic         first_en;
      rsp_item_type second;
      logic         second_en;
   } rsp_push_type;

endpackage

// ===== hdl/lef_kernel.sv =====
// Window shift and Laplacian magnitude with clamp to 8 bits.
module lef_kernel (
   input  lef_pkg::window_type             win,
   input  logic [lef_pkg::PIX_W-1:0]       up,
   input  logic [lef_pkg::PIX_W-1:0]       lo,
   input  logic [lef_pkg::PIX_W-1:0]       red,
   input  logic signed [lef_pkg::PIX_W-1:0] center_weight,
   output lef_pkg::window_type             win_next,
   output logic [lef_pkg::PIX_W-1:0]       mag
);

   logic [10:0]        nb_sum;
   logic signed [16:0] prod;
   logic signed [17:0] acc;
   logic [17:0]        acc_abs;

   always_comb begin
      win_next[0] = win[1];
      win_next[1] = win[2];
      win_next[2] = up;
      win_next[3] = win[4];
      win_next[4] = win[5];
      win_next[5] = lo;
      win_next[6] = win[7];
      win_next[7] = win[8];
      win_next[8] = red;
   end

   assign nb_sum = 11'(win_next[0]) + 11'(win_next[1]) + 11'(win_next[2])
                 + 11'(win_next[3]) + 11'(win_next[5]) + 11'(win_next[6])
                 + 11'(win_next[7]) + 11'(win_next[8]);

   assign prod    = center_weight * $signed({1'b0, win_next[4]});
   assign acc     = {prod[16], prod} - $signed({7'b0, nb_sum});
   assign acc_abs = acc[17] ? 18'(-acc) : 18'(acc);
   assign mag     = (acc_abs > 18'd255) ? 8'hFF : acc_abs[7:0];

endmodule

// ===== hdl/lef_rsp_fifo.sv =====
// Small result queue: takes up to two results a cycle, hands out one per transfer.
module lef_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  lef_pkg::rsp_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lef_pkg::rsp_item_type head
);

   localparam int PTR_W = $clog2(lef_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(lef_pkg::RSP_DEPTH + 1);

   lef_pkg::rsp_item_type entry_ff [lef_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       push_n;
   logic             pop;

   assign push_n    = 2'(push.first_en) + 2'(push.second_en);
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = entry_ff[rd_ptr_ff];
   // room for a full pair, regardless of this cycle's pop
   assign room      = (count_ff <= CNT_W'(lef_pkg::RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_en) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_en) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

// ===== hdl/laplacian_edge_filter_3x3_top.sv =====
// Streaming 3x3 Laplacian edge filter on the red channel, raster-order RGB in.
// One pixel is taken per clock while req_stall is low. A pixel passes an input
// register (with the two line-store reads registered alongside); its results
// enter a 4-entry queue once the queue has room for a pair, and the queue head
// drives the result port. The rate is set by the result port, one result per
// clock while rsp_stall is low: interior pixels are reported one row and one
// column late, when their lower-right neighbor arrives, and border pixels
// (first/last row, first/last column) pass through unchanged on their own
// arrival. A pixel yields 0, 1 or 2 results; the last column of each row from
// the third on and the bottom row from its third column on yield two, and
// elsewhere the filter runs at one pixel per clock while output is not stalled.
// The two line stores hold MAX_WIDTH entries each and are not cleared after reset.
module laplacian_edge_filter_3x3_top #(
   parameter int MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lef_pkg::PIX_W-1:0]            req_red_in,
   input  logic [lef_pkg::PIX_W-1:0]            req_green_in,
   input  logic [lef_pkg::PIX_W-1:0]            req_blue_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lef_pkg::COL_OUT_W-1:0]        rsp_out_col,
   output logic [lef_pkg::ROW_W-1:0]            rsp_out_row,
   output logic [lef_pkg::PIX_W-1:0]            rsp_red_out,
   output logic [lef_pkg::PIX_W-1:0]            rsp_green_out,
   output logic [lef_pkg::PIX_W-1:0]            rsp_blue_out,
   output logic                                 rsp_last_of_item,
   input  logic                                 csr_we,
   input  logic [lef_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [lef_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WCMP_W  = ($clog2(MAX_WIDTH + 1) > lef_pkg::FRAME_WIDTH_W) ?
                            $clog2(MAX_WIDTH + 1) : lef_pkg::FRAME_WIDTH_W;
   localparam int ROW_W   = lef_pkg::ROW_W;
   localparam int PIX_W   = lef_pkg::PIX_W;
   localparam logic [WCMP_W-1:0] MAX_W_V = WCMP_W'(MAX_WIDTH);
   localparam logic [WCMP_W-1:0] MIN_W_V = WCMP_W'(lef_pkg::MIN_DIM);
   localparam logic [ROW_W-1:0]  MIN_H_V = ROW_W'(lef_pkg::MIN_DIM);

   // configuration
   logic signed [PIX_W-1:0]                  cw_ff;
   logic [lef_pkg::FRAME_WIDTH_W-1:0]        fw_ff;
   logic [lef_pkg::FRAME_HEIGHT_W-1:0]       fh_ff;
   logic [WCMP_W-1:0] fw_ext, eff_w;
   logic [ROW_W-1:0]  eff_h;

   // raster position
   logic [COL_W-1:0]  col_ff, col_in, cur_col;
   logic [ROW_W-1:0]  row_ff, row_in, cur_row;
   logic              wrap_start, end_row;
   logic [ROW_W:0]    row_pre, row_inc;
   logic [WCMP_W-1:0] cur_col_x, col_inc;
   logic              cur_int, cur_brd;

   // input register stage
   logic              req_acc, room, a_adv;
   logic              a_valid_ff, a_valid_in;
   logic [PIX_W-1:0]  a_red_ff, a_grn_ff, a_blu_ff;
   logic [COL_W-1:0]  a_col_ff;
   logic [ROW_W-1:0]  a_row_ff;
   logic              a_int_ff, a_brd_ff;
   logic [PIX_W-1:0]  up_rd_ff, lo_rd_ff;
   logic [WCMP_W-1:0] a_col_x, a_colm1_x;

   logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  lower_mem [MAX_WIDTH];

   lef_pkg::window_type   win_ff, win_in;
   logic [PIX_W-1:0]      mag;
   lef_pkg::rsp_item_type int_item, brd_item, head;
   lef_pkg::rsp_push_type push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= lef_pkg::CENTER_WEIGHT_RST;
         fw_ff <= lef_pkg::FRAME_WIDTH_RST;
         fh_ff <= lef_pkg::FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            lef_pkg::CSR_CENTER_WEIGHT: cw_ff <= csr_wdata[PIX_W-1:0];
            lef_pkg::CSR_FRAME_WIDTH:   fw_ff <= csr_wdata[lef_pkg::FRAME_WIDTH_W-1:0];
            lef_pkg::CSR_FRAME_HEIGHT:  fh_ff <= csr_wdata[lef_pkg::FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign fw_ext = WCMP_W'(fw_ff);
   assign eff_w  = (fw_ext < MIN_W_V) ? MIN_W_V : ((fw_ext > MAX_W_V) ? MAX_W_V : fw_ext);
   assign eff_h  = (fh_ff < MIN_H_V) ? MIN_H_V : fh_ff;

   // position of the pixel on the input port; the start-of-step wrap only
   // matters after the frame size was lowered mid-frame
   always_comb begin
      wrap_start = (WCMP_W'(col_ff) >= eff_w);
      cur_col    = wrap_start ? '0 : col_ff;
      row_pre    = {1'b0, row_ff} + (ROW_W+1)'(wrap_start);
      cur_row    = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[ROW_W-1:0];
      cur_col_x  = WCMP_W'(cur_col);
      col_inc    = cur_col_x + WCMP_W'(1);
      end_row    = (col_inc >= eff_w);
      row_inc    = {1'b0, cur_row} + (ROW_W+1)'(1);
      col_in     = end_row ? '0 : col_inc[COL_W-1:0];
      if (end_row) begin
         row_in = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         row_in = cur_row;
      end
      cur_int    = (cur_row >= ROW_W'(2)) && (cur_col_x >= WCMP_W'(2));
      cur_brd    = (cur_row == '0) || (cur_row == eff_h - ROW_W'(1))
                || (cur_col == '0) || (cur_col_x == eff_w - WCMP_W'(1));
   end

   assign req_stall  = a_valid_ff && !room;
   assign req_acc    = req_valid && !req_stall;
   assign a_adv      = a_valid_ff && room;
   assign a_valid_in = req_acc ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (req_acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_red_ff <= req_red_in;
         a_grn_ff <= req_green_in;
         a_blu_ff <= req_blue_in;
         a_col_ff <= cur_col;
         a_row_ff <= cur_row;
         a_int_ff <= cur_int;
         a_brd_ff <= cur_brd;
      end
   end

   // line stores: read at transfer, rotate when the pixel leaves the input register;
   // the same column comes back at least three pixels later
   always_ff @(posedge clock) begin
      if (req_acc) begin
         up_rd_ff <= upper_mem[cur_col];
         lo_rd_ff <= lower_mem[cur_col];
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         upper_mem[a_col_ff] <= lo_rd_ff;
         lower_mem[a_col_ff] <= a_red_ff;
      end
   end

   lef_kernel u_kernel (
      .win           (win_ff),
      .up            (up_rd_ff),
      .lo            (lo_rd_ff),
      .red           (a_red_ff),
      .center_weight (cw_ff),
      .win_next      (win_in),
      .mag           (mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (a_adv) begin
         win_ff <= win_in;
      end
   end

   assign a_col_x   = WCMP_W'(a_col_ff);
   assign a_colm1_x = a_col_x - WCMP_W'(1);

   always_comb begin
      int_item.col   = a_colm1_x[lef_pkg::COL_OUT_W-1:0];
      int_item.row   = a_row_ff - ROW_W'(1);
      int_item.red   = mag;
      int_item.green = mag;
      int_item.blue  = mag;
      int_item.last  = !a_brd_ff;

      brd_item.col   = a_col_x[lef_pkg::COL_OUT_W-1:0];
      brd_item.row   = a_row_ff;
      brd_item.red   = a_red_ff;
      brd_item.green = a_grn_ff;
      brd_item.blue  = a_blu_ff;
      brd_item.last  = 1'b1;

      // interior result of the upper-left neighbor goes first
      push.first     = a_int_ff ? int_item : brd_item;
      push.first_en  = a_adv && (a_int_ff || a_brd_ff);
      push.second    = brd_item;
      push.second_en = a_adv && a_int_ff && a_brd_ff;
   end

   lef_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_out_col      = head.col;
   assign rsp_out_row      = head.row;
   assign rsp_red_out      = head.red;
   assign rsp_green_out    = head.green;
   assign rsp_blue_out     = head.blue;
   assign rsp_last_of_item = head.last;

endmodule

// ===== hdl/lef_checker.sv =====
// Port-level checks of the edge filter, bound to its top level.
`include "laplacian_edge_filter_3x3_top_assert.svh"

module lef_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [lef_pkg::COL_OUT_W-1:0]  rsp_out_col,
   input logic [lef_pkg::ROW_W-1:0]      rsp_out_row,
   input logic [lef_pkg::PIX_W-1:0]      rsp_red_out,
   input logic [lef_pkg::PIX_W-1:0]      rsp_green_out,
   input logic [lef_pkg::PIX_W-1:0]      rsp_blue_out,
   input logic                           rsp_last_of_item
);

   // a stalled result holds
   `LEF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_col) && $stable(rsp_out_row) && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_last_of_item), "stalled result changed")

   // the first of a pair is always the gray interior result
   `LEF_ASSERT_SAME(a_pair_gray, rsp_valid && !rsp_last_of_item, rsp_red_out == rsp_green_out && rsp_green_out == rsp_blue_out, "non-final result is not gray")

   // its border partner is queued with it and sits one row and one column on
   `LEF_ASSERT_NEXT(a_pair_next, rsp_valid && !rsp_stall && !rsp_last_of_item, rsp_valid && rsp_last_of_item && (rsp_out_row == $past(rsp_out_row) + 16'd1) && (rsp_out_col == $past(rsp_out_col) + 11'd1), "second result of a pixel missing or misplaced")

endmodule

bind laplacian_edge_filter_3x3_top lef_checker u_lef_checker (.*);

// ===== tb/laplacian_edge_filter_3x3_top_tb.sv =====
// Self-checking testbench for the streaming 3x3 Laplacian edge filter.
`timescale 1ns / 100ps

module laplacian_edge_filter_3x3_top_tb;

   localparam int MAX_W          = lef_pkg::MAX_WIDTH_DEF;
   localparam int MIN_DIM        = lef_pkg::MIN_DIM;
   localparam int PIX_W          = lef_pkg::PIX_W;
   localparam int COL_OUT_W      = lef_pkg::COL_OUT_W;
   localparam int ROW_W          = lef_pkg::ROW_W;
   localparam int FRAME_WIDTH_W  = lef_pkg::FRAME_WIDTH_W;
   localparam int FRAME_HEIGHT_W = lef_pkg::FRAME_HEIGHT_W;
   localparam int CSR_ADDR_W     = lef_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W     = lef_pkg::CSR_DATA_W;
   localparam int RAND_PIXELS    = 1300;
   localparam int SETTLE         = 8;
   localparam int CYCLE_LIMIT    = 4_000_000;
   localparam int PRINT_LIMIT    = 40;

   typedef enum int {RED_ANY, RED_BAND, RED_RAIL} red_mode_type;

   // one row of the directed table: a register write or a pixel
   typedef struct {
      bit                    is_write;
      logic [CSR_ADDR_W-1:0] idx;
      logic [CSR_DATA_W-1:0] val;
      logic [PIX_W-1:0]      red;
      logic [PIX_W-1:0]      grn;
      logic [PIX_W-1:0]      blu;
      bit                    typed;
      int                    ecol;
      int                    erow;
   } step_type;

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_red_in   = '0;
   logic [PIX_W-1:0]      req_green_in = '0;
   logic [PIX_W-1:0]      req_blue_in  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [COL_OUT_W-1:0]  rsp_out_col;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [PIX_W-1:0]      rsp_red_out;
   logic [PIX_W-1:0]      rsp_green_out;
   logic [PIX_W-1:0]      rsp_blue_out;
   logic                  rsp_last_of_item;
   logic                  csr_we       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   laplacian_edge_filter_3x3_top u_dut (.*);

   // filter state as seen from outside
   logic signed [PIX_W-1:0]    cfg_weight;
   logic [FRAME_WIDTH_W-1:0]   cfg_width;
   logic [FRAME_HEIGHT_W-1:0]  cfg_height;
   logic [PIX_W-1:0]           upper_line [MAX_W];
   logic [PIX_W-1:0]           lower_line [MAX_W];
   logic [PIX_W-1:0]           red_win [9];
   int unsigned                col_pos;
   int unsigned                row_pos;
   // line store columns 0 .. cols_written-1 hold pixel data
   int unsigned                cols_written;

   lef_pkg::rsp_item_type due_pixels [$];

   bit no_gaps;
   int stall_hold;
   int cycle_count;
   int mismatches;
   int results_seen;
   int pixels_sent;
   int reg_writes;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic step_type reg_step(input logic [CSR_ADDR_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] val);
      step_type s;
      s = '{default: 0};
      s.is_write = 1'b1;
      s.idx      = idx;
      s.val      = val;
      return s;
   endfunction

   function automatic step_type pix_step(input logic [PIX_W-1:0] red, grn, blu);
      step_type s;
      s = '{default: 0};
      s.red = red;
      s.grn = grn;
      s.blu = blu;
      return s;
   endfunction

   // border pixel whose single result is the pixel itself at (col, row)
   function automatic step_type border_step(input logic [PIX_W-1:0] red, grn, blu,
                                            input int col, input int row);
      step_type s;
      s       = pix_step(red, grn, blu);
      s.typed = 1'b1;
      s.ecol  = col;
      s.erow  = row;
      return s;
   endfunction

   function automatic int unsigned clamp_width(input logic [FRAME_WIDTH_W-1:0] fw);
      int unsigned w;
      w = fw;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned clamp_height(input logic [FRAME_HEIGHT_W-1:0] fh);
      int unsigned h;
      h = fh;
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   // pixels still to go in the current frame, counting from the next one
   function automatic longint frame_left();
      longint w, h, c, r;
      w = clamp_width(cfg_width);
      h = clamp_height(cfg_height);
      c = col_pos;
      r = row_pos;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) r = 0;
      return (h - r) * w - c;
   endfunction

   function automatic bit next_is_origin();
      longint w, h;
      w = clamp_width(cfg_width);
      h = clamp_height(cfg_height);
      return frame_left() == w * h;
   endfunction

   // advance the filter by one pixel; returns the 0..2 results it releases
   task automatic filter_pixel(input logic [PIX_W-1:0] red, grn, blu,
                               output lef_pkg::rsp_item_type res [2], output int n);
      int unsigned w, h, c, r;
      int acc;
      logic [PIX_W-1:0] up, lo;
      w = clamp_width(cfg_width);
      h = clamp_height(cfg_height);
      // size may have shrunk under the current position
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      up = upper_line[c];
      lo = lower_line[c];
      upper_line[c] = lo;
      lower_line[c] = red;
      if (c + 1 > cols_written) cols_written = c + 1;
      red_win[0] = red_win[1]; red_win[1] = red_win[2];
      red_win[3] = red_win[4]; red_win[4] = red_win[5];
      red_win[6] = red_win[7]; red_win[7] = red_win[8];
      red_win[2] = up;
      red_win[5] = lo;
      red_win[8] = red;
      n = 0;
      if (r >= 2 && c >= 2) begin
         acc = int'(cfg_weight) * int'(red_win[4]);
         for (int i = 0; i < 9; i++)
            if (i != 4) acc -= int'(red_win[i]);
         if (acc < 0) acc = -acc;
         if (acc > 255) acc = 255;
         res[n] = lef_pkg::rsp_item_type'{col: COL_OUT_W'(c - 1), row: ROW_W'(r - 1),
                                          red: PIX_W'(acc), green: PIX_W'(acc),
                                          blue: PIX_W'(acc), last: 1'b0};
         n++;
      end
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
         res[n] = lef_pkg::rsp_item_type'{col: COL_OUT_W'(c), row: ROW_W'(r),
                                          red: red, green: grn, blue: blu,
                                          last: 1'b0};
         n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   function automatic int pick_gap();
      int sel;
      if (no_gaps) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 88) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [PIX_W-1:0] rand_red(input red_mode_type mode, input int base);
      case (mode)
         RED_BAND: return PIX_W'(base + $urandom_range(0, 6));
         RED_RAIL: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:  return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_weight();
      int sel;
      logic signed [PIX_W-1:0] wt;
      sel = $urandom_range(0, 99);
      if (sel < 10)      wt = -8'sd128;
      else if (sel < 20) wt = 8'sd127;
      else if (sel < 28) wt = 8'sd0;
      else if (sel < 35) wt = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
      else if (sel < 65) wt = PIX_W'($urandom_range(6, 10));
      else               wt = PIX_W'($urandom_range(0, 255));
      return {{(CSR_DATA_W-PIX_W){wt[PIX_W-1]}}, wt};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return CSR_DATA_W'($urandom_range(3, 10));
      if (sel < 75) return CSR_DATA_W'($urandom_range(0, 2));
      if (sel < 87) return CSR_DATA_W'($urandom_range(11, 40));
      if (sel < 94) return CSR_DATA_W'($urandom_range(2049, 4095));
      return (sel < 97) ? 16'd2047 : 16'd2048;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return CSR_DATA_W'($urandom_range(3, 8));
      if (sel < 75) return CSR_DATA_W'($urandom_range(0, 2));
      if (sel < 88) return CSR_DATA_W'($urandom_range(9, 30));
      if (sel < 94) return 16'hFFFF;
      return CSR_DATA_W'($urandom_range(0, 65535));
   endfunction

   task automatic wait_idle(input int settle);
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      wait_idle(SETTLE);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lef_pkg::CSR_CENTER_WEIGHT: cfg_weight = val[PIX_W-1:0];
         lef_pkg::CSR_FRAME_WIDTH:   cfg_width  = val[FRAME_WIDTH_W-1:0];
         lef_pkg::CSR_FRAME_HEIGHT:  cfg_height = val[FRAME_HEIGHT_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] red, grn, blu,
                             input bit typed = 1'b0, input int ecol = 0,
                             input int erow = 0);
      lef_pkg::rsp_item_type res [2];
      int n, gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= red;
      req_green_in <= grn;
      req_blue_in  <= blu;
      do @(posedge clock); while (req_stall !== 1'b0);
      filter_pixel(red, grn, blu, res, n);
      if (typed)
         due_pixels.push_back(lef_pkg::rsp_item_type'{col: COL_OUT_W'(ecol),
                                                      row: ROW_W'(erow),
                                                      red: red, green: grn,
                                                      blue: blu, last: 1'b1});
      else
         for (int i = 0; i < n; i++) due_pixels.push_back(res[i]);
      pixels_sent++;
   endtask

   task automatic flag_field(input string name, input logic [15:0] want, got);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
   endtask

   // output side: random stall with short and long bursts and quiet stretches
   always @(posedge clock) begin : stall_gen
      int roll;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
         end else if (roll < 65) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(20, 60);
         end else if (roll < 95) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(10, 30);
         end
      end
   end

   always @(posedge clock) begin : check_results
      lef_pkg::rsp_item_type seen, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen = lef_pkg::rsp_item_type'{col: rsp_out_col, row: rsp_out_row,
                                        red: rsp_red_out, green: rsp_green_out,
                                        blue: rsp_blue_out, last: rsp_last_of_item};
         results_seen++;
         if (due_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: expected no transfer, got col %0d row %0d rgb %0d/%0d/%0d",
                        $time, seen.col, seen.row, seen.red, seen.green, seen.blue);
         end else begin
            want = due_pixels.pop_front();
            if (seen.col !== want.col)     flag_field("out_col", want.col, seen.col);
            if (seen.row !== want.row)     flag_field("out_row", want.row, seen.row);
            if (seen.red !== want.red)     flag_field("red_out", want.red, seen.red);
            if (seen.green !== want.green) flag_field("green_out", want.green, seen.green);
            if (seen.blue !== want.blue)   flag_field("blue_out", want.blue, seen.blue);
            if (seen.last !== want.last)   flag_field("last_of_item", want.last, seen.last);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stalled, %0d results still due", $time, due_pixels.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      step_type              plan [$];
      red_mode_type          mode;
      int                    rand_pixels, directed_pixels, phases, span, base;
      logic [CSR_DATA_W-1:0] wval;
      longint                left;

      cfg_weight   = lef_pkg::CENTER_WEIGHT_RST;
      cfg_width    = lef_pkg::FRAME_WIDTH_RST;
      cfg_height   = lef_pkg::FRAME_HEIGHT_RST;
      col_pos      = 0;
      row_pos      = 0;
      cols_written = 0;
      foreach (red_win[i]) red_win[i] = '0;
      foreach (upper_line[i]) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      rand_pixels = 0;
      phases      = 0;
      no_gaps     = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      plan = {
         reg_step(lef_pkg::CSR_FRAME_WIDTH, 16'd0),     // below range, acts as 3
         reg_step(lef_pkg::CSR_FRAME_HEIGHT, 16'd1),    // below range, acts as 3
         // 3x3 frame with the reset weight, small unclamped magnitude
         border_step(8'd255, 8'd255, 8'd255, 0, 0),
         border_step(8'd0, 8'd0, 8'd0, 1, 0),
         border_step(8'd10, 8'hA5, 8'h5A, 2, 0),
         border_step(8'd10, 8'h5A, 8'hA5, 0, 1),
         pix_step(8'd20, 8'd1, 8'd2),
         border_step(8'd10, 8'd3, 8'd4, 2, 1),
         border_step(8'd10, 8'd5, 8'd6, 0, 2),
         border_step(8'd10, 8'd7, 8'd8, 1, 2),
         pix_step(8'd10, 8'd9, 8'd10),
         // largest weight, bright center: clamps high
         reg_step(lef_pkg::CSR_CENTER_WEIGHT, 16'h007F),
         border_step(8'd0, 8'd255, 8'd0, 0, 0),
         border_step(8'd0, 8'd0, 8'd255, 1, 0),
         border_step(8'd0, 8'd128, 8'd1, 2, 0),
         border_step(8'd0, 8'd1, 8'd128, 0, 1),
         pix_step(8'd255, 8'd0, 8'd0),
         border_step(8'd0, 8'd127, 8'd254, 2, 1),
         border_step(8'd0, 8'd2, 8'd253, 0, 2),
         border_step(8'd0, 8'd0, 8'd0, 1, 2),
         pix_step(8'd0, 8'd0, 8'd0),
         // most negative weight, then the row is cut short mid-frame
         reg_step(lef_pkg::CSR_CENTER_WEIGHT, 16'hFF80),
         reg_step(lef_pkg::CSR_FRAME_WIDTH, 16'd6),
         border_step(8'd255, 8'd0, 8'd0, 0, 0),
         border_step(8'd255, 8'd1, 8'd1, 1, 0),
         border_step(8'd255, 8'd2, 8'd2, 2, 0),
         border_step(8'd255, 8'd3, 8'd3, 3, 0),
         reg_step(lef_pkg::CSR_FRAME_WIDTH, 16'd3),     // column 4 now past the end
         border_step(8'd255, 8'd4, 8'd4, 0, 1),
         pix_step(8'd255, 8'd5, 8'd5),
         border_step(8'd255, 8'd6, 8'd6, 2, 1),
         border_step(8'd255, 8'd7, 8'd7, 0, 2),
         border_step(8'd255, 8'd8, 8'd8, 1, 2),
         pix_step(8'd255, 8'd9, 8'd9)
      };
      foreach (plan[k]) begin
         if (plan[k].is_write)
            write_reg(plan[k].idx, plan[k].val);
         else
            send_pixel(plan[k].red, plan[k].grn, plan[k].blu,
                       plan[k].typed, plan[k].ecol, plan[k].erow);
      end
      directed_pixels = pixels_sent;

      while (rand_pixels < RAND_PIXELS) begin
         if ($urandom_range(0, 99) < 40)
            write_reg(lef_pkg::CSR_CENTER_WEIGHT, pick_weight());
         if ($urandom_range(0, 99) < 40) begin
            wval = pick_width();
            // mid-frame a wider row may only reach line store columns holding data
            if (!next_is_origin() &&
                clamp_width(wval[FRAME_WIDTH_W-1:0]) > cols_written)
               wval = CSR_DATA_W'(cols_written);
            write_reg(lef_pkg::CSR_FRAME_WIDTH, wval);
         end
         if ($urandom_range(0, 99) < 35)
            write_reg(lef_pkg::CSR_FRAME_HEIGHT, pick_height());
         no_gaps = ($urandom_range(0, 4) == 0);
         mode    = red_mode_type'($urandom_range(0, 2));
         base    = $urandom_range(0, 249);
         left    = frame_left();
         // often run a small frame to its end so that wider rows can start
         if ($urandom_range(0, 9) < 3 && left <= 200)
            span = int'(left);
         else if ($urandom_range(0, 9) == 0)
            span = $urandom_range(100, 200);
         else
            span = $urandom_range(5, 60);
         repeat (span) begin
            send_pixel(rand_red(mode, base), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)));
            rand_pixels++;
         end
         phases++;
      end

      req_valid <= 1'b0;
      wait_idle(12);

      $display("Ran %0d pixels: %0d directed, %0d random, rows up to %0d columns wide",
               pixels_sent, directed_pixels, rand_pixels, cols_written);
      $display("%0d results checked, %0d register writes over %0d random phases",
               results_seen, reg_writes, phases);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== laplacian_edge_filter_3x3_top.f =====
+incdir+hdl
hdl/lef_pkg.sv
hdl/lef_kernel.sv
hdl/lef_rsp_fifo.sv
hdl/laplacian_edge_filter_3x3_top.sv
hdl/lef_checker.sv
tb/laplacian_edge_filter_3x3_top_tb.sv
